>>> rtl/core/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

    // fixed field widths
    localparam int KEY_W  = 32;
    localparam int SLOT_W = 4;
    localparam int FILL_W = 5;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // default number of heap entries
    localparam int DEPTH_DEF = 16;

    // stream word widths, whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    // key reported when extracting from an empty heap
    localparam logic signed [KEY_W-1:0] EMPTY_KEY = 32'sd1000000000;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_DECREASE = 2'd2,
        OP_DELETE   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEL_RD,
        ST_DEL_CAP,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_EX_RD0,
        ST_EX_RDL,
        ST_EX_LAST,
        ST_DN_CHK,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_FIN_RD,
        ST_FIN_CAP
    } state_t;

    // one result word handed from the sequencer to the output stage
    typedef struct packed {
        logic [FILL_W-1:0]       fill;
        logic                    min_valid;
        logic signed [KEY_W-1:0] min_key;
        logic signed [KEY_W-1:0] key_out;
        status_t                 status;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/mhpq_ram.sv
`default_nettype none

module mhpq_ram #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                                aclk,
    input  wire logic                                wr_en,
    input  wire logic [AW-1:0]                       wr_addr,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]   wr_data,
    input  wire logic                                rd_en,
    input  wire logic [AW-1:0]                       rd_addr,
    output logic signed [mhpq_pkg::KEY_W-1:0]        rd_data
);

    logic signed [mhpq_pkg::KEY_W-1:0] mem [DEPTH];
    logic signed [mhpq_pkg::KEY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/mhpq_seq.sv
`default_nettype none

module mhpq_seq #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // operation in
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire mhpq_pkg::op_t                       in_op,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]   in_key,
    input  wire logic [mhpq_pkg::SLOT_W-1:0]         in_slot,
    // result out
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output mhpq_pkg::res_t                           res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > mhpq_pkg::SLOT_W) ? CW : mhpq_pkg::SLOT_W;

    // heap memory port
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [mhpq_pkg::KEY_W-1:0] mem_wdata;
    logic                              mem_re;
    logic [AW-1:0]                     mem_raddr;
    logic signed [mhpq_pkg::KEY_W-1:0] mem_rdata;

    mhpq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // control state
    mhpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;

    // working registers
    logic [AW-1:0]                     pos_reg, pos_next;
    logic signed [mhpq_pkg::KEY_W-1:0] val_reg, val_next;
    logic signed [mhpq_pkg::KEY_W-1:0] lval_reg, lval_next;
    logic signed [mhpq_pkg::KEY_W-1:0] kout_reg, kout_next;
    mhpq_pkg::status_t                 status_reg, status_next;
    logic                              top_reg, top_next;
    logic                              del_reg, del_next;

    // index arithmetic
    logic [AW-1:0]  parent_idx;
    logic [AW:0]    lidx;
    logic [AW:0]    ridx;
    logic [AW:0]    count_ext;
    logic           l_in;
    logic           r_in;
    logic           full;
    logic           slot_bad;
    logic [AW-1:0]  slot_idx;
    logic           go_l;
    logic           go_r;
    logic signed [mhpq_pkg::KEY_W-1:0] best_val;

    assign parent_idx = (pos_reg - 1'b1) >> 1;
    assign lidx       = {pos_reg, 1'b1};
    assign ridx       = lidx + 1'b1;
    assign count_ext  = (AW+1)'(count_reg);
    assign l_in       = lidx < count_ext;
    assign r_in       = ridx < count_ext;
    assign full       = count_reg >= CW'(DEPTH);
    assign slot_bad   = CMPW'(in_slot) >= CMPW'(count_reg);
    assign slot_idx   = AW'(in_slot);

    // child selection, left wins ties
    assign go_l     = lval_reg < val_reg;
    assign best_val = go_l ? lval_reg : val_reg;
    assign go_r     = r_in && (mem_rdata < best_val);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mhpq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        lval_reg   <= lval_next;
        kout_reg   <= kout_next;
        status_reg <= status_next;
        top_reg    <= top_next;
        del_reg    <= del_next;
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        lval_next   = lval_reg;
        kout_next   = kout_reg;
        status_next = status_reg;
        top_next    = top_reg;
        del_next    = del_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            mhpq_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    status_next = mhpq_pkg::STAT_OK;
                    kout_next   = '0;
                    top_next    = 1'b0;
                    del_next    = 1'b0;
                    case (in_op)
                        mhpq_pkg::OP_INSERT: begin
                            if (full) begin
                                status_next = mhpq_pkg::STAT_FULL;
                                state_next  = mhpq_pkg::ST_FIN_RD;
                            end else begin
                                pos_next   = AW'(count_reg);
                                val_next   = in_key;
                                count_next = count_reg + 1'b1;
                                state_next = mhpq_pkg::ST_UP_CHK;
                            end
                        end
                        mhpq_pkg::OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                status_next = mhpq_pkg::STAT_EMPTY;
                                kout_next   = mhpq_pkg::EMPTY_KEY;
                                state_next  = mhpq_pkg::ST_FIN_RD;
                            end else begin
                                state_next = mhpq_pkg::ST_EX_RD0;
                            end
                        end
                        mhpq_pkg::OP_DECREASE: begin
                            if (slot_bad) begin
                                status_next = mhpq_pkg::STAT_RANGE;
                                state_next  = mhpq_pkg::ST_FIN_RD;
                            end else begin
                                pos_next   = slot_idx;
                                val_next   = in_key;
                                state_next = mhpq_pkg::ST_UP_CHK;
                            end
                        end
                        mhpq_pkg::OP_DELETE: begin
                            if (slot_bad) begin
                                status_next = mhpq_pkg::STAT_RANGE;
                                state_next  = mhpq_pkg::ST_FIN_RD;
                            end else begin
                                pos_next   = slot_idx;
                                top_next   = 1'b1;
                                del_next   = 1'b1;
                                state_next = mhpq_pkg::ST_DEL_RD;
                            end
                        end
                        default: begin
                            state_next = mhpq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // fetch the entry being deleted
            mhpq_pkg::ST_DEL_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = pos_reg;
                state_next = mhpq_pkg::ST_DEL_CAP;
            end

            mhpq_pkg::ST_DEL_CAP: begin
                kout_next  = mem_rdata;
                state_next = mhpq_pkg::ST_UP_CHK;
            end

            // sift up: stop at the root or fetch the parent
            mhpq_pkg::ST_UP_CHK: begin
                if (pos_reg == '0) begin
                    if (top_reg) begin
                        state_next = mhpq_pkg::ST_EX_RDL;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = val_reg;
                        state_next = mhpq_pkg::ST_FIN_RD;
                    end
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = parent_idx;
                    state_next = mhpq_pkg::ST_UP_CMP;
                end
            end

            // move a larger parent down (any parent when deleting), or settle the key here
            mhpq_pkg::ST_UP_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (top_reg || (mem_rdata > val_reg)) begin
                    mem_wdata  = mem_rdata;
                    pos_next   = parent_idx;
                    state_next = mhpq_pkg::ST_UP_CHK;
                end else begin
                    mem_wdata  = val_reg;
                    state_next = mhpq_pkg::ST_FIN_RD;
                end
            end

            // extract: read the root, then the last entry
            mhpq_pkg::ST_EX_RD0: begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = mhpq_pkg::ST_EX_RDL;
            end

            mhpq_pkg::ST_EX_RDL: begin
                if (!del_reg) begin
                    kout_next = mem_rdata;
                end
                mem_re     = 1'b1;
                mem_raddr  = AW'(count_reg - 1'b1);
                state_next = mhpq_pkg::ST_EX_LAST;
            end

            mhpq_pkg::ST_EX_LAST: begin
                val_next   = mem_rdata;
                count_next = count_reg - 1'b1;
                pos_next   = '0;
                if (count_reg == CW'(1)) begin
                    state_next = mhpq_pkg::ST_FIN_RD;
                end else begin
                    state_next = mhpq_pkg::ST_DN_CHK;
                end
            end

            // sift down: settle at a leaf or fetch the left child
            mhpq_pkg::ST_DN_CHK: begin
                if (!l_in) begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    state_next = mhpq_pkg::ST_FIN_RD;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = lidx[AW-1:0];
                    state_next = mhpq_pkg::ST_DN_RDR;
                end
            end

            mhpq_pkg::ST_DN_RDR: begin
                lval_next  = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = ridx[AW-1:0];
                state_next = mhpq_pkg::ST_DN_CMP;
            end

            // pull the smaller child up, or settle the key here
            mhpq_pkg::ST_DN_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (go_r) begin
                    mem_wdata  = mem_rdata;
                    pos_next   = ridx[AW-1:0];
                    state_next = mhpq_pkg::ST_DN_CHK;
                end else if (go_l) begin
                    mem_wdata  = lval_reg;
                    pos_next   = lidx[AW-1:0];
                    state_next = mhpq_pkg::ST_DN_CHK;
                end else begin
                    mem_wdata  = val_reg;
                    state_next = mhpq_pkg::ST_FIN_RD;
                end
            end

            // fetch the root for the result word
            mhpq_pkg::ST_FIN_RD: begin
                mem_re     = count_reg != '0;
                mem_raddr  = '0;
                state_next = mhpq_pkg::ST_FIN_CAP;
            end

            mhpq_pkg::ST_FIN_CAP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    // result word
    always_comb begin
        res.status    = status_reg;
        res.key_out   = kout_reg;
        res.min_valid = count_reg != '0;
        res.min_key   = (count_reg != '0) ? mem_rdata : '0;
        res.fill      = mhpq_pkg::FILL_W'(count_reg);
    end

endmodule

`default_nettype wire

>>> rtl/core/min_heap_priority_queue.sv
`default_nettype none

// channel  dir  word                                                   handshake
// s_       in   op[1:0] key_in[33:2] slot[37:34], zero pad to 40       s_tvalid/s_tready
// m_       out  status[1:0] key_out[33:2] min_key[65:34]               m_tvalid/m_tready
//               min_valid[66] fill[71:67]
//
// One operation at a time, paced by the single read port. Insert and decrease key sift up
// level by level; extract reads the root and the last entry, then, unless that was the
// only entry, sifts down level by level; delete climbs its entry to the root, then finishes
// as extract does; rejected operations go straight to the result word.
// Synchronous active-low reset empties the heap; memory contents are not cleared.
// A waiting result in the output register lets the next word in; the one after that stalls.

module min_heap_priority_queue #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // op[1:0], key_in[33:2], slot[37:34], zeros above
    input  wire logic [mhpq_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], key_out[33:2], min_key[65:34], min_valid[66], fill[71:67]
    output logic [mhpq_pkg::M_TDATA_W-1:0]         m_tdata
);

    mhpq_pkg::op_t                     in_op;
    logic signed [mhpq_pkg::KEY_W-1:0] in_key;
    logic [mhpq_pkg::SLOT_W-1:0]       in_slot;

    logic           res_valid;
    logic           res_ready;
    mhpq_pkg::res_t res;

    logic           m_valid_reg;
    mhpq_pkg::res_t m_res_reg;

    // unpack the input word
    assign in_op   = mhpq_pkg::op_t'(s_tdata[1:0]);
    assign in_key  = s_tdata[33:2];
    assign in_slot = s_tdata[37:34];

    mhpq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (in_op),
        .in_key    (in_key),
        .in_slot   (in_slot),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    // pack the result word
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.fill, m_res_reg.min_valid, m_res_reg.min_key,
                       m_res_reg.key_out, m_res_reg.status};

endmodule

`default_nettype wire
